// ===== src/fws_pkg.sv =====
// Shared constants, register indexes and an elaboration-time divider for the waveshaper.
`timescale 1ns / 1ps
package fws_pkg;
	localparam int unsigned ONE_Q12 = 4096;
	localparam int unsigned ONE_Q15 = 32768;
	localparam longint unsigned ONE_Q30 = 64'd1073741824;
	localparam int unsigned BIAS_SCALE_Q12 = 1229;
	localparam int unsigned TANH_SPAN_Q12 = 32768;
	localparam int unsigned EXP_SPAN_Q12 = 65536;
	localparam int unsigned SERIES_TERMS = 24;

	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 15;
	localparam logic [CFG_IDX_W-1:0] REG_DRIVE_GAIN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HARDNESS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BIAS_OFFSET = 2'd2;

	// restoring long division, used only to build constant tables
	function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
		logic [64:0] r;
		logic [63:0] q;
		r = '0;
		q = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[63:0], n[i]};
			if (r >= {1'b0, d}) begin
				r = r - {1'b0, d};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction
endpackage

// ===== src/fws_curve.sv =====
// Pipelined tanh/diode blend curve: Q12 argument in, signed Q27 blend out.
`timescale 1ns / 1ps
module fws_curve #(
	parameter int unsigned DEPTH = 256
) (
	input  logic               clk,
	input  logic [5:0]         en,
	input  logic signed [20:0] v,
	input  logic [12:0]        h,
	output logic signed [28:0] y
);
	import fws_pkg::*;

	localparam int unsigned IW = $clog2(DEPTH + 1);
	localparam logic [IW-1:0] LAST = IW'(DEPTH);
	typedef logic [15:0] rom_t [0:DEPTH];

	function automatic rom_t build_rom(input logic sel_tanh);
		rom_t r;
		logic [63:0] yy, term, ratio, e;
		yy = udiv(64'd16 << 30, 64'(DEPTH));
		term = ONE_Q30;
		ratio = ONE_Q30;
		e = ONE_Q30;
		for (int k = 1; k <= SERIES_TERMS; k++) begin
			term = udiv((term * yy) >> 30, 64'(k));
			if (k % 2 == 1) ratio = ratio - term;
			else ratio = ratio + term;
		end
		for (int i = 0; i <= DEPTH; i++) begin
			if (sel_tanh)
				r[i] = 16'(udiv(((ONE_Q30 - e) << 15) + ((ONE_Q30 + e) >> 1), ONE_Q30 + e));
			else
				r[i] = 16'((e + 64'd16384) >> 15);
			e = (e * ratio + 64'd536870912) >> 30;
		end
		return r;
	endfunction

	localparam rom_t EXP_ROM = build_rom(1'b0);
	localparam rom_t TANH_ROM = build_rom(1'b1);

	// stage 3: magnitude, tanh position, diode argument product
	logic               neg_s3;
	logic [15+IW:0]     post_s3;
	logic [35:0]        am_s3;
	logic [19:0]        m;
	logic [15:0]        u;
	logic [15:0]        slope;
	assign m = v[20] ? 20'(-v) : 20'(v);
	assign u = (m > 20'(TANH_SPAN_Q12)) ? 16'(TANH_SPAN_Q12) : m[15:0];
	assign slope = 16'(ONE_Q12) + 16'(h) * 16'd7;
	always_ff @(posedge clk) begin
		if (en[0]) begin
			neg_s3 <= v[20];
			post_s3 <= (16+IW)'(u) * (16+IW)'(DEPTH);
			am_s3 <= 36'(slope) * 36'(m);
		end
	end

	// stage 4: tanh lookup, clamp diode argument, exp position
	logic [IW-1:0] tidx, tidx1;
	logic [23:0]   tfull;
	logic [16:0]   t;
	logic [15:0]   ta, tb;
	logic          neg_s4, tdir_s4;
	logic [15:0]   ta_s4, tdiff_s4, tfrac_s4;
	logic [16+IW:0] pose_s4;
	assign tidx = post_s3[15 +: IW];
	assign tidx1 = (tidx >= LAST) ? LAST : tidx + 1'b1;
	assign ta = TANH_ROM[tidx];
	assign tb = TANH_ROM[tidx1];
	assign tfull = 24'((am_s3 + 36'd2048) >> 12);
	assign t = (tfull > 24'(EXP_SPAN_Q12)) ? 17'(EXP_SPAN_Q12) : tfull[16:0];
	always_ff @(posedge clk) begin
		if (en[1]) begin
			neg_s4 <= neg_s3;
			ta_s4 <= ta;
			tdir_s4 <= tb >= ta;
			tdiff_s4 <= (tb >= ta) ? tb - ta : ta - tb;
			tfrac_s4 <= {post_s3[14:0], 1'b0};
			pose_s4 <= (17+IW)'(t) * (17+IW)'(DEPTH);
		end
	end

	// stage 5: tanh slope product, exp lookup
	logic [IW-1:0] eidx, eidx1;
	logic [15:0]   ea, eb;
	logic          neg_s5, tdir_s5, edir_s5;
	logic [15:0]   ta_s5, ea_s5, ediff_s5, efrac_s5;
	logic [31:0]   tprod_s5;
	assign eidx = pose_s4[16 +: IW];
	assign eidx1 = (eidx >= LAST) ? LAST : eidx + 1'b1;
	assign ea = EXP_ROM[eidx];
	assign eb = EXP_ROM[eidx1];
	always_ff @(posedge clk) begin
		if (en[2]) begin
			neg_s5 <= neg_s4;
			ta_s5 <= ta_s4;
			tdir_s5 <= tdir_s4;
			tprod_s5 <= 32'(tdiff_s4) * 32'(tfrac_s4);
			ea_s5 <= ea;
			edir_s5 <= eb >= ea;
			ediff_s5 <= (eb >= ea) ? eb - ea : ea - eb;
			efrac_s5 <= pose_s4[15:0];
		end
	end

	// stage 6: finish tanh, exp slope product
	logic [15:0] tstep;
	logic        neg_s6, edir_s6;
	logic [15:0] soft_s6, ea_s6;
	logic [31:0] eprod_s6;
	assign tstep = 16'((33'(tprod_s5) + 33'd32768) >> 16);
	always_ff @(posedge clk) begin
		if (en[3]) begin
			neg_s6 <= neg_s5;
			soft_s6 <= tdir_s5 ? ta_s5 + tstep : ta_s5 - tstep;
			ea_s6 <= ea_s5;
			edir_s6 <= edir_s5;
			eprod_s6 <= 32'(ediff_s5) * 32'(efrac_s5);
		end
	end

	// stage 7: finish exp, weight both curves
	logic [15:0] estep, ev, hard;
	logic        neg_s7;
	logic [28:0] ps_s7, ph_s7;
	assign estep = 16'((33'(eprod_s6) + 33'd32768) >> 16);
	assign ev = edir_s6 ? ea_s6 + estep : ea_s6 - estep;
	assign hard = 16'(ONE_Q15) - ev;
	always_ff @(posedge clk) begin
		if (en[4]) begin
			neg_s7 <= neg_s6;
			ps_s7 <= 29'(soft_s6) * 29'(13'(ONE_Q12) - h);
			ph_s7 <= 29'(hard) * 29'(h);
		end
	end

	// stage 8: blend and restore sign
	logic [28:0] mag;
	assign mag = ps_s7 + ph_s7;
	always_ff @(posedge clk) begin
		if (en[5]) y <= neg_s7 ? -$signed(mag) : $signed(mag);
	end
endmodule

// ===== src/fuzz_waveshaper.sv =====
// Top level of the fuzz waveshaper: config registers, input scaling, curve pipes, output.
`timescale 1ns / 1ps
// Fuzz waveshaper: each Q1.15 item is scaled by drive_gain (Q7.8), offset by 0.3 times
// bias_offset (Q12), and sent through a blend of a tanh curve and a diode curve
// sign(v)*(1-exp(-(1+7h)|v|)) weighted by hardness h (Q12, saturated at 1.0). The blend of
// the bias alone is subtracted so silence stays silent, and the result is rounded and
// saturated to Q1.15. The block is a nine-stage pipeline: an item may enter every cycle
// while the output side is ready. A stalled output holds the last stage; bubbles ahead
// of it still close up, so input stays ready until every stage holds an item. The tanh
// and exp tables have CURVE_TABLE_DEPTH+1 points each and are constant logic built at
// elaboration. Write configuration only while the pipeline is empty; a write to an
// unknown index is dropped.
module fuzz_waveshaper #(
	parameter int unsigned CURVE_TABLE_DEPTH = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [15:0]             sample_in,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [15:0]             sample_out,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [fws_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fws_pkg::CFG_DATA_W-1:0] cfg_data
);
	import fws_pkg::*;

	// configuration registers; always ready for a write
	logic [14:0]        drive_q;
	logic [12:0]        hard_q;
	logic signed [13:0] bias_q;
	logic [12:0]        h;
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_q <= 15'd6400;
			hard_q <= 13'd2867;
			bias_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_DRIVE_GAIN:  drive_q <= cfg_data;
				REG_HARDNESS:    hard_q <= cfg_data[12:0];
				REG_BIAS_OFFSET: bias_q <= cfg_data[13:0];
				default: ;
			endcase
		end
	end
	// saturate hardness above one
	assign h = (hard_q > 13'(ONE_Q12)) ? 13'(ONE_Q12) : hard_q;

	// stall control: a stage advances when it is empty or the next stage advances
	logic [9:1] vld_q;
	logic [9:1] en;
	always_comb begin
		en[9] = !vld_q[9] || out_ready;
		for (int k = 8; k >= 1; k--) en[k] = !vld_q[k] || en[k+1];
	end
	assign in_ready = en[1];
	assign out_valid = vld_q[9];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) vld_q[1] <= in_valid;
			for (int k = 2; k <= 9; k++) begin
				if (en[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	// stage 1: magnitude products for the drive and the bias
	logic [15:0] smag;
	logic [13:0] bmag;
	logic        sneg_s1, bneg_s1;
	logic [30:0] sprod_s1;
	logic [24:0] bprod_s1;
	assign smag = sample_in[15] ? 16'(-sample_in) : 16'(sample_in);
	assign bmag = bias_q[13] ? 14'(-bias_q) : 14'(bias_q);
	always_ff @(posedge clk) begin
		if (en[1]) begin
			sneg_s1 <= sample_in[15];
			bneg_s1 <= bias_q[13];
			sprod_s1 <= 31'(smag) * 31'(drive_q);
			bprod_s1 <= 25'(bmag) * 25'(BIAS_SCALE_Q12);
		end
	end

	// stage 2: round half away from zero, form curve argument and rest point
	logic [19:0]        sq;
	logic [12:0]        bq;
	logic signed [20:0] sv, rv;
	logic signed [20:0] v_s2, rest_s2;
	assign sq = 20'((32'(sprod_s1) + 32'd1024) >> 11);
	assign bq = 13'((26'(bprod_s1) + 26'd2048) >> 12);
	assign sv = sneg_s1 ? -$signed({1'b0, sq}) : $signed({1'b0, sq});
	assign rv = bneg_s1 ? -$signed(21'(bq)) : $signed(21'(bq));
	always_ff @(posedge clk) begin
		if (en[2]) begin
			v_s2 <= sv + rv;
			rest_s2 <= rv;
		end
	end

	// stages 3 to 8: the shaped value and the bias rest point go through twin curve pipes
	logic signed [28:0] cv_s8, cr_s8;
	fws_curve #(.DEPTH(CURVE_TABLE_DEPTH)) u_curve_sig (
		.clk (clk),
		.en  (en[8:3]),
		.v   (v_s2),
		.h   (h),
		.y   (cv_s8)
	);
	fws_curve #(.DEPTH(CURVE_TABLE_DEPTH)) u_curve_rest (
		.clk (clk),
		.en  (en[8:3]),
		.v   (rest_s2),
		.h   (h),
		.y   (cr_s8)
	);

	// stage 9: remove the rest point, round Q27 to Q15, saturate
	logic signed [29:0] diff;
	logic signed [17:0] rnd;
	assign diff = 30'(cv_s8) - 30'(cr_s8);
	assign rnd = 18'((diff + 30'sd2048) >>> 12);
	always_ff @(posedge clk) begin
		if (en[9]) begin
			if (rnd > 18'sd32767) sample_out <= 16'sd32767;
			else if (rnd < -18'sd32768) sample_out <= -16'sd32768;
			else sample_out <= rnd[15:0];
		end
	end

	// input backpressure only when every stage is full
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (&vld_q))
		else $error("input stalled with an empty stage");
	// an accepted item lands in stage 1
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> vld_q[1])
		else $error("accepted item lost at stage 1");
	// after a result is taken, the last stage refills from the stage before it
	a_refill: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[9] && out_ready) |=> (vld_q[9] == $past(vld_q[8])))
		else $error("output stage refill mismatch");
endmodule
